/* src/u2u_pkg.sv */
// Shared types and constants for the UTF-16 to UTF-8 transcoder.
// Used by the front end, the job queue and the byte emitter.
`timescale 1ns / 1ps
`default_nettype none

package u2u_pkg;

   // Configuration register
   localparam int unsigned MAX_UNITS_W = 24;
   localparam logic [MAX_UNITS_W-1:0] MAX_UNITS_RESET = 24'd262144;

   // UTF-16 surrogate ranges and code point base
   localparam logic [15:0] SUR_HIGH_LO = 16'hD800;
   localparam logic [15:0] SUR_HIGH_HI = 16'hDBFF;
   localparam logic [15:0] SUR_LOW_LO  = 16'hDC00;
   localparam logic [15:0] SUR_LOW_HI  = 16'hDFFF;
   localparam logic [20:0] SUPP_BASE   = 21'h10000;
   localparam int unsigned SUR_SHIFT   = 10;

   // Code point limits that pick the UTF-8 length
   localparam logic [20:0] LIM_ONE   = 21'h80;
   localparam logic [20:0] LIM_TWO   = 21'h800;
   localparam logic [20:0] LIM_THREE = 21'h10000;

   // UTF-8 marker bits
   localparam logic [7:0] LEAD_TWO   = 8'hC0;
   localparam logic [7:0] LEAD_THREE = 8'hE0;
   localparam logic [7:0] LEAD_FOUR  = 8'hF0;
   localparam logic [7:0] CONT_MARK  = 8'h80;

   // Encoded length minus one
   typedef enum logic [1:0] {
      LEN_ONE   = 2'd0,
      LEN_TWO   = 2'd1,
      LEN_THREE = 2'd2,
      LEN_FOUR  = 2'd3
   } len_type;

   // Job queue geometry
   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned QUEUE_AW    = 2;

   // One classified job handed from the front end to the emitter
   typedef struct packed {
      logic        err;       // emit a single error word
      logic        eot;       // unit closed its string
      len_type     len;       // byte count minus one
      logic [20:0] cp;        // code point to encode
   } job_type;

endpackage

`default_nettype wire

/* src/u2u_queue.sv */
// Small job queue between the front end and the byte emitter.
// Depends on u2u_pkg for the job type and queue depth.
`timescale 1ns / 1ps
`default_nettype none

module u2u_queue (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire u2u_pkg::job_type push_job,
   output logic                  full,
   input  wire logic             pop,
   output logic                  head_valid,
   output u2u_pkg::job_type      head_job
);

   localparam int unsigned AW = u2u_pkg::QUEUE_AW;

   u2u_pkg::job_type slot_ff [u2u_pkg::QUEUE_DEPTH];
   logic [AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [AW:0]   count_ff, count_in;
   logic          do_push, do_pop;

   assign full       = (count_ff == (AW+1)'(u2u_pkg::QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_job   = slot_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store pushed job
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

`default_nettype wire

/* src/u2u_front.sv */
// Front end: accepts code units, tracks surrogates, length and failure,
// and pushes one classified job per unit that yields output. Uses u2u_pkg.
`timescale 1ns / 1ps
`default_nettype none

module u2u_front #(
   parameter int unsigned COUNT_WIDTH = 24
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_ready,
   input  wire logic [15:0]                     req_code_unit,
   input  wire logic                            req_end_of_text,
   input  wire logic [u2u_pkg::MAX_UNITS_W-1:0] max_units,
   input  wire logic                            q_full,
   output logic                                 q_push,
   output u2u_pkg::job_type                     q_job
);

   localparam int unsigned CMP_W =
      (COUNT_WIDTH > u2u_pkg::MAX_UNITS_W) ? COUNT_WIDTH : u2u_pkg::MAX_UNITS_W;

   logic                   pending_ff, pending_in;
   logic [9:0]             high_bits_ff, high_bits_in;
   logic [COUNT_WIDTH-1:0] count_ff, count_in;
   logic                   failed_ff, failed_in;

   logic                   accept;
   logic                   is_high, is_low;
   logic [COUNT_WIDTH-1:0] count_inc;
   logic                   too_long;
   logic [20:0]            pair_cp;
   logic [20:0]            bmp_cp;

   assign req_ready = !q_full;
   assign accept    = req_valid && req_ready;

   // Classify the unit
   assign is_high = (req_code_unit >= u2u_pkg::SUR_HIGH_LO) &&
                    (req_code_unit <= u2u_pkg::SUR_HIGH_HI);
   assign is_low  = (req_code_unit >= u2u_pkg::SUR_LOW_LO) &&
                    (req_code_unit <= u2u_pkg::SUR_LOW_HI);

   // Saturating unit count and length check
   assign count_inc = (count_ff == '1) ? count_ff : count_ff + 1'b1;
   assign too_long  = CMP_W'(count_inc) > CMP_W'(max_units);

   // Supplementary code point from the held high half and this low half
   assign pair_cp = u2u_pkg::SUPP_BASE + 21'({high_bits_ff, req_code_unit[9:0]});
   assign bmp_cp  = 21'(req_code_unit);

   always_comb begin
      pending_in   = pending_ff;
      high_bits_in = high_bits_ff;
      count_in     = count_ff;
      failed_in    = failed_ff;
      q_push       = 1'b0;
      q_job.err    = 1'b0;
      q_job.eot    = req_end_of_text;
      q_job.len    = u2u_pkg::LEN_ONE;
      q_job.cp     = bmp_cp;

      if (accept) begin
         if (failed_ff) begin
            // Drop units of a failed string
         end else begin
            count_in = count_inc;
            if (too_long) begin
               q_push    = 1'b1;
               q_job.err = 1'b1;
               failed_in = 1'b1;
            end else if (pending_ff) begin
               pending_in   = 1'b0;
               high_bits_in = '0;
               q_push       = 1'b1;
               if (!is_low) begin
                  q_job.err = 1'b1;
                  failed_in = 1'b1;
               end else begin
                  q_job.cp  = pair_cp;
                  q_job.len = u2u_pkg::LEN_FOUR;
               end
            end else if (is_high) begin
               if (req_end_of_text) begin
                  q_push    = 1'b1;
                  q_job.err = 1'b1;
               end else begin
                  pending_in   = 1'b1;
                  high_bits_in = req_code_unit[9:0];
               end
            end else if (is_low) begin
               q_push    = 1'b1;
               q_job.err = 1'b1;
               failed_in = 1'b1;
            end else begin
               q_push = 1'b1;
               if (bmp_cp < u2u_pkg::LIM_ONE) begin
                  q_job.len = u2u_pkg::LEN_ONE;
               end else if (bmp_cp < u2u_pkg::LIM_TWO) begin
                  q_job.len = u2u_pkg::LEN_TWO;
               end else begin
                  q_job.len = u2u_pkg::LEN_THREE;
               end
            end
         end
         // Close the string on its final unit
         if (req_end_of_text) begin
            pending_in   = 1'b0;
            high_bits_in = '0;
            count_in     = '0;
            failed_in    = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff   <= 1'b0;
         high_bits_ff <= '0;
         count_ff     <= '0;
         failed_ff    <= 1'b0;
      end else begin
         pending_ff   <= pending_in;
         high_bits_ff <= high_bits_in;
         count_ff     <= count_in;
         failed_ff    <= failed_in;
      end
   end

endmodule

`default_nettype wire

/* src/u2u_back.sv */
// Back end: pops queue jobs and, while rsp_ready holds, emits one UTF-8 word
// per cycle via the output register. Uses u2u_pkg for the job type and markers.
`timescale 1ns / 1ps
`default_nettype none

module u2u_back (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             head_valid,
   input  wire u2u_pkg::job_type head_job,
   output logic                  pop,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output logic [7:0]            rsp_out_byte,
   output logic                  rsp_last,
   output logic                  rsp_done_res,
   output logic                  rsp_error
);

   logic [1:0] idx_ff, idx_in;
   logic       valid_ff, valid_in;
   logic [7:0] byte_ff, byte_in;
   logic       last_ff, done_ff, error_ff;
   logic       load, fin;
   logic [1:0] from_end;
   logic [7:0] lead, cont;
   logic [20:0] cp;

   assign cp       = head_job.cp;
   assign load     = head_valid && (!valid_ff || rsp_ready);
   assign fin      = head_job.err || (idx_ff == head_job.len);
   assign pop      = load && fin;
   assign from_end = head_job.len - idx_ff;

   // Lead byte by length
   always_comb begin
      unique case (head_job.len)
         u2u_pkg::LEN_ONE:   lead = {1'b0, cp[6:0]};
         u2u_pkg::LEN_TWO:   lead = u2u_pkg::LEAD_TWO   | 8'(cp[10:6]);
         u2u_pkg::LEN_THREE: lead = u2u_pkg::LEAD_THREE | 8'(cp[15:12]);
         u2u_pkg::LEN_FOUR:  lead = u2u_pkg::LEAD_FOUR  | 8'(cp[20:18]);
         default:            lead = '0;
      endcase
   end

   // Continuation byte by its distance from the end
   always_comb begin
      case (from_end)
         2'd0:    cont = u2u_pkg::CONT_MARK | 8'(cp[5:0]);
         2'd1:    cont = u2u_pkg::CONT_MARK | 8'(cp[11:6]);
         default: cont = u2u_pkg::CONT_MARK | 8'(cp[17:12]);
      endcase
   end

   always_comb begin
      if (head_job.err) begin
         byte_in = '0;
      end else if (idx_ff == 2'd0) begin
         byte_in = lead;
      end else begin
         byte_in = cont;
      end
      idx_in   = idx_ff;
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
         idx_in   = fin ? 2'd0 : idx_ff + 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   // Hold the word in the output register
   always_ff @(posedge clock) begin
      if (load) begin
         byte_ff  <= byte_in;
         last_ff  <= fin;
         done_ff  <= fin && head_job.eot && !head_job.err;
         error_ff <= head_job.err;
      end
   end

   assign rsp_valid    = valid_ff;
   assign rsp_out_byte = byte_ff;
   assign rsp_last     = last_ff;
   assign rsp_done_res = done_ff;
   assign rsp_error    = error_ff;

endmodule

`default_nettype wire

/* src/utf16_to_utf8_transcoder.sv */
// UTF-16 to UTF-8 transcoder top level: front end, job queue, byte emitter
// and the max_units register. Depends on u2u_pkg and the three submodules.
//
// One UTF-16 code unit is taken per word; a unit that yields output occupies
// the emitter for one word per UTF-8 byte (1 to 4), an error for one word,
// and a unit that yields nothing (a held high surrogate, or a unit of a
// string that already failed) passes the front end without a job. The
// emitter's output register, one word per cycle while rsp_ready is high,
// sets the sustained rate; a four-job queue lets the front end keep accepting
// while a longer sequence drains. After an error word the rest of that string
// is dropped until the unit that carries end_of_text. The user must write
// max_units through csr_wr_en/csr_wr_data only while the block is idle, which it does not enforce.
`timescale 1ns / 1ps
`default_nettype none

module utf16_to_utf8_transcoder #(
   parameter int unsigned COUNT_WIDTH = 24
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [15:0] req_code_unit,
   input  wire logic        req_end_of_text,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [7:0]       rsp_out_byte,
   output logic             rsp_last,
   output logic             rsp_done_res,
   output logic             rsp_error,
   input  wire logic        csr_wr_en,
   input  wire logic [23:0] csr_wr_data
);

   logic [u2u_pkg::MAX_UNITS_W-1:0] max_units_ff, max_units_in;
   logic             q_full, q_push, q_pop, q_head_valid;
   u2u_pkg::job_type q_push_job, q_head_job;

   // Update the length limit register
   assign max_units_in = csr_wr_en ? csr_wr_data : max_units_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_units_ff <= u2u_pkg::MAX_UNITS_RESET;
      end else begin
         max_units_ff <= max_units_in;
      end
   end

   u2u_front #(
      .COUNT_WIDTH(COUNT_WIDTH)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_code_unit  (req_code_unit),
      .req_end_of_text(req_end_of_text),
      .max_units      (max_units_ff),
      .q_full         (q_full),
      .q_push         (q_push),
      .q_job          (q_push_job)
   );

   u2u_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_job  (q_push_job),
      .full      (q_full),
      .pop       (q_pop),
      .head_valid(q_head_valid),
      .head_job  (q_head_job)
   );

   u2u_back u_back (
      .clock       (clock),
      .reset       (reset),
      .head_valid  (q_head_valid),
      .head_job    (q_head_job),
      .pop         (q_pop),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_out_byte(rsp_out_byte),
      .rsp_last    (rsp_last),
      .rsp_done_res(rsp_done_res),
      .rsp_error   (rsp_error)
   );

endmodule

`default_nettype wire

/* src/u2u_checker.sv */
// Port-level checks for the UTF-16 to UTF-8 transcoder, bound to its top.
// Depends only on the top level's ports.
`timescale 1ns / 1ps
`default_nettype none

module u2u_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic [7:0] rsp_out_byte,
   input wire logic       rsp_last,
   input wire logic       rsp_done_res,
   input wire logic       rsp_error
);

   // An error word is a lone zero word that closes its unit
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_error |-> rsp_out_byte == 8'd0 && rsp_last && !rsp_done_res)
      else $error("error word malformed");

   // A string completes only on the last word of its unit
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_done_res |-> rsp_last)
      else $error("done without last");

   // Nothing is shown right after reset
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("word valid after reset");

   // A stalled word holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_byte)
         && $stable(rsp_last) && $stable(rsp_error))
      else $error("stalled word changed");

endmodule

bind utf16_to_utf8_transcoder u2u_checker u_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_out_byte(rsp_out_byte),
   .rsp_last    (rsp_last),
   .rsp_done_res(rsp_done_res),
   .rsp_error   (rsp_error)
);

`default_nettype wire

/* dv/utf16_to_utf8_transcoder_test.sv */
// Self-checking bench for utf16_to_utf8_transcoder: queued UTF-16 strings, a predictor
// of the UTF-8 byte stream and a scoreboard on the result channel.
// Depends on u2u_pkg and the transcoder RTL.
`timescale 1ns / 1ps

module utf16_to_utf8_transcoder_test;

   localparam int STALL_LIMIT   = 2000;
   localparam int SETTLE_CYCLES = 8;
   localparam logic [23:0] MAX_UNITS_TOP = 24'hFFFFFF;
   localparam logic [23:0] COUNT_TOP     = 24'hFFFFFF;

   typedef struct packed {
      logic [15:0] code;
      logic        eot;
   } utf16_word_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       last;
      logic       done_res;
      logic       error;
   } utf8_word_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [15:0] req_code_unit = '0;
   logic        req_end_of_text = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [7:0]  rsp_out_byte;
   logic        rsp_last;
   logic        rsp_done_res;
   logic        rsp_error;
   logic        csr_wr_en = 1'b0;
   logic [23:0] csr_wr_data = '0;

   // Stimulus and expected byte stream
   utf16_word_type pending_units[$];
   utf8_word_type  utf8_expected[$];
   utf16_word_type next_word;
   utf8_word_type  want;

   // Predictor copy of the string state and the register
   logic [23:0] limit_units = u2u_pkg::MAX_UNITS_RESET;
   logic        pend_high = 1'b0;
   logic [9:0]  pend_high_bits = '0;
   logic [23:0] str_units = '0;
   logic        str_failed = 1'b0;

   int idle_pct = 30;
   int units_queued = 0;
   int units_accepted = 0;
   int words_seen = 0;
   int error_words = 0;
   int strings_done = 0;
   int csr_writes = 0;
   int mismatch_count = 0;
   int stall_cycles = 0;

   utf16_to_utf8_transcoder #(
      .COUNT_WIDTH(24)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_code_unit(req_code_unit),
      .req_end_of_text(req_end_of_text),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_out_byte(rsp_out_byte),
      .rsp_last(rsp_last),
      .rsp_done_res(rsp_done_res),
      .rsp_error(rsp_error),
      .csr_wr_en(csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   // 20 ns clock
   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   // Count a failure; print only the first few
   task automatic flag_failure(input string msg);
      if (mismatch_count < 10) begin
         $display("%s", msg);
      end
      mismatch_count++;
   endtask

   // Predict the UTF-8 words caused by one accepted code unit
   task automatic transcode_unit(input logic [15:0] cu, input logic eot);
      logic          is_high;
      logic          is_low;
      logic          bad;
      logic          emit;
      logic [20:0]   cp;
      logic [7:0]    seq [4];
      int            n;
      utf8_word_type w;
      is_high = (cu >= u2u_pkg::SUR_HIGH_LO) && (cu <= u2u_pkg::SUR_HIGH_HI);
      is_low  = (cu >= u2u_pkg::SUR_LOW_LO) && (cu <= u2u_pkg::SUR_LOW_HI);
      bad  = 1'b0;
      emit = 1'b0;
      cp   = '0;
      n    = 0;
      if (!str_failed) begin
         if (str_units != COUNT_TOP) begin
            str_units = str_units + 1'b1;
         end
         if (str_units > limit_units) begin
            bad = 1'b1;
         end else if (pend_high) begin
            if (!is_low) begin
               bad = 1'b1;
            end else begin
               cp = u2u_pkg::SUPP_BASE + {1'b0, pend_high_bits, cu[9:0]};
               pend_high = 1'b0;
               pend_high_bits = '0;
               emit = 1'b1;
            end
         end else if (is_high) begin
            if (eot) begin
               bad = 1'b1;
            end else begin
               pend_high = 1'b1;
               pend_high_bits = cu[9:0];
            end
         end else if (is_low) begin
            bad = 1'b1;
         end else begin
            cp = {5'd0, cu};
            emit = 1'b1;
         end

         // One error word, then drop the rest of the string
         if (bad) begin
            w.out_byte = 8'h00;
            w.last = 1'b1;
            w.done_res = 1'b0;
            w.error = 1'b1;
            utf8_expected.insert(utf8_expected.size(), w);
            str_failed = 1'b1;
         end

         // Split the code point into 1 to 4 bytes
         if (emit) begin
            if (cp < u2u_pkg::LIM_ONE) begin
               seq[0] = cp[7:0];
               n = 1;
            end else if (cp < u2u_pkg::LIM_TWO) begin
               seq[0] = u2u_pkg::LEAD_TWO | {3'd0, cp[10:6]};
               seq[1] = u2u_pkg::CONT_MARK | {2'd0, cp[5:0]};
               n = 2;
            end else if (cp < u2u_pkg::LIM_THREE) begin
               seq[0] = u2u_pkg::LEAD_THREE | {4'd0, cp[15:12]};
               seq[1] = u2u_pkg::CONT_MARK | {2'd0, cp[11:6]};
               seq[2] = u2u_pkg::CONT_MARK | {2'd0, cp[5:0]};
               n = 3;
            end else begin
               seq[0] = u2u_pkg::LEAD_FOUR | {5'd0, cp[20:18]};
               seq[1] = u2u_pkg::CONT_MARK | {2'd0, cp[17:12]};
               seq[2] = u2u_pkg::CONT_MARK | {2'd0, cp[11:6]};
               seq[3] = u2u_pkg::CONT_MARK | {2'd0, cp[5:0]};
               n = 4;
            end
            for (int k = 0; k < n; k++) begin
               w.out_byte = seq[k];
               w.last = (k == n - 1);
               w.done_res = (k == n - 1) && eot;
               w.error = 1'b0;
               utf8_expected.insert(utf8_expected.size(), w);
            end
         end
      end

      // End of text clears the string state, failed or not
      if (eot) begin
         pend_high = 1'b0;
         pend_high_bits = '0;
         str_units = '0;
         str_failed = 1'b0;
      end
   endtask

   task automatic push_unit(input logic [15:0] code, input logic eot);
      utf16_word_type u;
      u.code = code;
      u.eot = eot;
      pending_units.insert(pending_units.size(), u);
      units_queued++;
   endtask

   // Queue one string: mostly valid content, optionally with a surrogate fault
   task automatic queue_string(input int len, input bit broken);
      logic [15:0] units[$];
      int          kind;
      int          fault;
      while (units.size() < len) begin
         kind = $urandom_range(0, 99);
         if (kind < 30) begin
            units.insert(units.size(), 16'($urandom_range(0, 16'h7F)));
         end else if (kind < 50) begin
            units.insert(units.size(), 16'($urandom_range(16'h80, 16'h7FF)));
         end else if (kind < 70) begin
            if ($urandom_range(0, 1)) begin
               units.insert(units.size(), 16'($urandom_range(16'h800, 16'hD7FF)));
            end else begin
               units.insert(units.size(), 16'($urandom_range(16'hE000, 16'hFFFF)));
            end
         end else if (kind < 90) begin
            units.insert(units.size(),
               u2u_pkg::SUR_HIGH_LO + 16'($urandom_range(0, 1023)));
            units.insert(units.size(),
               u2u_pkg::SUR_LOW_LO + 16'($urandom_range(0, 1023)));
         end else begin
            units.insert(units.size(), 16'($urandom));
         end
      end
      if (broken) begin
         fault = $urandom_range(0, 2);
         case (fault)
            0: begin
               units.insert(units.size(),
                  u2u_pkg::SUR_LOW_LO + 16'($urandom_range(0, 1023)));
            end
            1: begin
               units.insert(units.size(),
                  u2u_pkg::SUR_HIGH_LO + 16'($urandom_range(0, 1023)));
               units.insert(units.size(), 16'($urandom_range(0, 16'hD7FF)));
            end
            default: begin
               units.insert(units.size(),
                  u2u_pkg::SUR_HIGH_LO + 16'($urandom_range(0, 1023)));
            end
         endcase
         // Trailing units after the fault get dropped by the block
         if (fault != 2) begin
            repeat ($urandom_range(0, 2)) units.insert(units.size(), 16'($urandom));
         end
      end
      foreach (units[i]) begin
         push_unit(units[i], i == units.size() - 1);
      end
   endtask

   task automatic queue_random(input int target);
      int stop;
      stop = units_queued + target;
      while (units_queued < stop) begin
         queue_string($urandom_range(1, 8), $urandom_range(0, 99) < 15);
      end
   endtask

   // Wait until every queued word is in and every expected word is out
   task automatic wait_idle();
      while (pending_units.size() != 0 || req_valid || utf8_expected.size() != 0) begin
         @(negedge clock);
      end
   endtask

   // Write max_units between phases, once the block has drained
   task automatic write_max_units(input logic [23:0] value);
      wait_idle();
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      limit_units = value;
      csr_writes++;
      @(negedge clock);
   endtask

   // Driver: hold the word until accepted, then advance or idle
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_code_unit <= '0;
         req_end_of_text <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            transcode_unit(req_code_unit, req_end_of_text);
            units_accepted++;
         end
         if (!req_valid || req_ready) begin
            if (pending_units.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
               next_word = pending_units.pop_front();
               req_valid <= 1'b1;
               req_code_unit <= next_word.code;
               req_end_of_text <= next_word.eot;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: stall at random, check each word against the oldest expectation
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) >= idle_pct);
         if (rsp_valid && rsp_ready) begin
            words_seen++;
            if (rsp_error) begin
               error_words++;
            end
            if (rsp_done_res) begin
               strings_done++;
            end
            if (utf8_expected.size() == 0) begin
               flag_failure($sformatf("unexpected word: byte %02h last %b done %b error %b",
                  rsp_out_byte, rsp_last, rsp_done_res, rsp_error));
            end else begin
               want = utf8_expected.pop_front();
               if (rsp_out_byte !== want.out_byte || rsp_last !== want.last ||
                   rsp_done_res !== want.done_res || rsp_error !== want.error) begin
                  flag_failure($sformatf(
                     "word %0d mismatch: byte %02h/%02h last %b/%b done %b/%b error %b/%b",
                     words_seen, rsp_out_byte, want.out_byte, rsp_last, want.last,
                     rsp_done_res, want.done_res, rsp_error, want.error));
               end
            end
         end
      end
   end

   // Watchdog: end the run when neither channel moves for too long
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("timeout: no word moved for %0d cycles", STALL_LIMIT);
         $display("utf16_to_utf8_transcoder_test: done, errors");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed strings at the reset limit
      push_unit(16'h0000, 1'b1);
      push_unit(16'h007F, 1'b1);
      push_unit(16'h0080, 1'b0);
      push_unit(16'h07FF, 1'b1);
      push_unit(16'h0800, 1'b0);
      push_unit(16'hD7FF, 1'b0);
      push_unit(16'hE000, 1'b0);
      push_unit(16'hFFFF, 1'b1);
      push_unit(16'hD800, 1'b0);
      push_unit(16'hDC00, 1'b1);
      push_unit(16'hDBFF, 1'b0);
      push_unit(16'hDFFF, 1'b1);
      // unpaired high surrogate, then a dropped unit
      push_unit(16'hD800, 1'b0);
      push_unit(16'h0041, 1'b0);
      push_unit(16'h0042, 1'b1);
      // high surrogate closing the string
      push_unit(16'h0041, 1'b0);
      push_unit(16'hDBFF, 1'b1);
      // lone low surrogates
      push_unit(16'hDC00, 1'b0);
      push_unit(16'hDFFF, 1'b1);
      push_unit(16'hDFFF, 1'b1);

      // Largest limit, no idling on either side
      write_max_units(MAX_UNITS_TOP);
      idle_pct = 0;
      queue_random(130);

      // One unit per string: the second unit is too long
      write_max_units(24'd1);
      idle_pct = 30;
      push_unit(16'h0041, 1'b0);
      push_unit(16'h0042, 1'b1);
      push_unit(16'h00E9, 1'b1);
      queue_random(40);

      // Zero limit: the first unit already fails
      write_max_units(24'd0);
      push_unit(16'h0041, 1'b1);
      push_unit(16'h0042, 1'b0);
      push_unit(16'h0043, 1'b1);
      push_unit(16'hD800, 1'b1);

      write_max_units(24'd4);
      queue_random(120);

      write_max_units(24'($urandom_range(2, 12)));
      queue_random(120);

      // Drain and settle
      wait_idle();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (utf8_expected.size() != 0) begin
         flag_failure($sformatf("%0d expected words never arrived", utf8_expected.size()));
      end

      $display("covered %0d code units and %0d result words over %0d max_units settings",
         units_accepted, words_seen, csr_writes);
      $display("of those, %0d error words and %0d strings completed; %0d failures",
         error_words, strings_done, mismatch_count);
      if (mismatch_count == 0) begin
         $display("utf16_to_utf8_transcoder_test: done, clean");
      end else begin
         $display("utf16_to_utf8_transcoder_test: done, errors");
      end
      $finish;
   end

endmodule
